>>> hdl/i2cbb_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and phase tables for the I2C bit-bang master.
// No dependencies.
package i2cbb_pkg;

	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_START   = 3'd1;
	localparam logic [2:0] OP_STOP    = 3'd2;
	localparam logic [2:0] OP_WRITE   = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;
	localparam logic [2:0] OP_SEND_ACK = 3'd5;
	localparam logic [2:0] OP_RECV_ACK = 3'd6;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
	localparam logic [7:0]  BIT_MSB         = 8'h80;

	typedef struct packed {
		logic [2:0] bit_idx;
		logic [1:0] sub;
	} bit_phase_t;

	// Phase count of each command.
	function automatic logic [4:0] phase_total(input logic [2:0] cmd);
		logic [4:0] n;
		begin
			unique case (cmd)
				OP_START:    n = 5'd4;
				OP_STOP:     n = 5'd3;
				OP_WRITE:    n = 5'd24;
				OP_READ:     n = 5'd25;
				OP_SEND_ACK: n = 5'd3;
				OP_RECV_ACK: n = 5'd4;
				default:     n = 5'd0;
			endcase
			return n;
		end
	endfunction

	// Split a phase number into bit (p / 3, modulo 8) and sub-phase (p % 3).
	// p * 11 >> 5 equals p / 3 for every 5-bit p.
	function automatic bit_phase_t split_phase(input logic [4:0] p);
		logic [8:0] prod;
		logic [3:0] quo;
		logic [5:0] three_q;
		bit_phase_t r;
		begin
			prod    = {4'd0, p} * 9'd11;
			quo     = prod[8:5];
			three_q = {2'd0, quo} * 6'd3;
			r.bit_idx = quo[2:0];
			r.sub     = 2'({1'b0, p} - three_q);
			return r;
		end
	endfunction

endpackage

>>> hdl/i2c_bit_bang_master_unit.sv
`timescale 1ns / 1ps
// I2C bit-bang master: pin phase sequencer with a registered result stage.
// Depends on i2cbb_pkg.
//
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  op, tx_byte, ack_out, sda_in
// out      output     out_valid/out_ready  scl_level, sda_level, busy_res,
//                                          done_res, rx_byte, ack_in
// cfg      input      cfg_we               cfg_data (phase_ticks)
//
// One transaction per cycle while in_ready is high: each accepted tick updates the
// sequencer state and loads the result register in the same cycle.
// in_ready drops only while a result is held and out_ready is low.
// Reset releases both sequencer pin states, clears the sequencer and sets phase_ticks to 10.
module i2c_bit_bang_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  tx_byte,
	input  logic        ack_out,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic        ack_in,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);

	logic [15:0] phase_ticks_q;
	logic [2:0]  act_q, act_n;
	logic [4:0]  phase_q, phase_n;
	logic [15:0] tick_q, tick_n;
	logic [7:0]  shift_q, shift_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic [7:0]  rbyte_q, rbyte_n;
	logic        rack_q, rack_n;
	logic        done_n;

	logic        out_valid_q;
	logic        scl_res_q, sda_res_q, busy_res_q, done_res_q, ack_res_q;
	logic [7:0]  rx_res_q;

	logic        accept;
	logic [15:0] limit;
	logic        do_en;
	logic [2:0]  ph_cmd;
	logic [4:0]  ph_p;
	logic [4:0]  ph_next;
	logic [4:0]  ph_m1;
	i2cbb_pkg::bit_phase_t wr_bp, rd_bp;

	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;
	assign limit    = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
	assign ph_next  = phase_q + 5'd1;

	always_comb begin
		act_n   = act_q;
		phase_n = phase_q;
		tick_n  = tick_q;
		shift_n = shift_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		rbyte_n = rbyte_q;
		rack_n  = rack_q;
		done_n  = 1'b0;
		do_en   = 1'b0;
		ph_cmd  = act_q;
		ph_p    = phase_q;

		if (act_q == i2cbb_pkg::OP_NONE) begin
			if (op != i2cbb_pkg::OP_NONE && op <= i2cbb_pkg::OP_RECV_ACK) begin
				act_n   = op;
				phase_n = 5'd0;
				tick_n  = 16'd1;
				if (op == i2cbb_pkg::OP_WRITE)
					shift_n = tx_byte;
				else if (op == i2cbb_pkg::OP_SEND_ACK)
					shift_n = {7'd0, ack_out};
				else
					shift_n = 8'd0;
				do_en  = 1'b1;
				ph_cmd = op;
				ph_p   = 5'd0;
			end
		end else if (tick_q >= limit) begin
			if (ph_next >= i2cbb_pkg::phase_total(act_q)) begin
				// last phase ran out: finish and go idle
				if (act_q == i2cbb_pkg::OP_READ)
					rbyte_n = shift_q;
				act_n   = i2cbb_pkg::OP_NONE;
				phase_n = 5'd0;
				tick_n  = 16'd0;
				done_n  = 1'b1;
			end else begin
				phase_n = ph_next;
				tick_n  = 16'd1;
				do_en   = 1'b1;
				ph_p    = ph_next;
			end
		end else begin
			tick_n = tick_q + 16'd1;
		end

		ph_m1 = ph_p - 5'd1;
		wr_bp = i2cbb_pkg::split_phase(ph_p);
		rd_bp = i2cbb_pkg::split_phase(ph_m1);

		if (do_en) begin
			unique case (ph_cmd)
				i2cbb_pkg::OP_START: begin
					if (ph_p == 5'd0)      sda_n = 1'b1;
					else if (ph_p == 5'd1) scl_n = 1'b1;
					else if (ph_p == 5'd2) sda_n = 1'b0;
					else                   scl_n = 1'b0;
				end
				i2cbb_pkg::OP_STOP: begin
					if (ph_p == 5'd0)      sda_n = 1'b0;
					else if (ph_p == 5'd1) scl_n = 1'b1;
					else                   sda_n = 1'b1;
				end
				i2cbb_pkg::OP_WRITE: begin
					if (wr_bp.sub == 2'd0)
						sda_n = |(shift_n & (i2cbb_pkg::BIT_MSB >> wr_bp.bit_idx));
					else if (wr_bp.sub == 2'd1)
						scl_n = 1'b1;
					else
						scl_n = 1'b0;
				end
				i2cbb_pkg::OP_READ: begin
					if (ph_p == 5'd0)
						sda_n = 1'b1;
					else if (rd_bp.sub == 2'd0)
						scl_n = 1'b1;
					else if (rd_bp.sub == 2'd1) begin
						if (sda_in)
							shift_n = shift_n | (i2cbb_pkg::BIT_MSB >> rd_bp.bit_idx);
					end else
						scl_n = 1'b0;
				end
				i2cbb_pkg::OP_SEND_ACK: begin
					if (ph_p == 5'd0)      sda_n = shift_n[0];
					else if (ph_p == 5'd1) scl_n = 1'b1;
					else                   scl_n = 1'b0;
				end
				i2cbb_pkg::OP_RECV_ACK: begin
					if (ph_p == 5'd0)      sda_n = 1'b1;
					else if (ph_p == 5'd1) scl_n = 1'b1;
					else if (ph_p == 5'd2) rack_n = sda_in;
					else                   scl_n = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cbb_pkg::PHASE_TICKS_RST;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= i2cbb_pkg::OP_NONE;
			phase_q <= 5'd0;
			tick_q  <= 16'd0;
			shift_q <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rbyte_q <= 8'd0;
			rack_q  <= 1'b1;
		end else if (accept) begin
			act_q   <= act_n;
			phase_q <= phase_n;
			tick_q  <= tick_n;
			shift_q <= shift_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			rbyte_q <= rbyte_n;
			rack_q  <= rack_n;
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scl_res_q  <= scl_n;
			sda_res_q  <= sda_n;
			busy_res_q <= (act_n != i2cbb_pkg::OP_NONE);
			done_res_q <= done_n;
			rx_res_q   <= rbyte_n;
			ack_res_q  <= rack_n;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = scl_res_q;
	assign sda_level = sda_res_q;
	assign busy_res  = busy_res_q;
	assign done_res  = done_res_q;
	assign rx_byte   = rx_res_q;
	assign ack_in    = ack_res_q;

endmodule
